[rtl/clas_pkg.sv]
// Package for the command-line argument splitter.
// Holds character constants, the quote-state type and the result and queue entry structs.
// No dependencies; every other file of the block refers to it by scoped names.
package clas_pkg;

    // Character width and the characters that the splitter reacts to.
    localparam int CHAR_BITS = 8;
    localparam int COUNT_BITS = 16;

    localparam logic [CHAR_BITS-1:0] CH_NUL   = CHAR_BITS'(8'h00);
    localparam logic [CHAR_BITS-1:0] CH_TAB   = CHAR_BITS'(8'h09);
    localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(8'h20);
    localparam logic [CHAR_BITS-1:0] CH_QUOTE = CHAR_BITS'(8'h22);
    localparam logic [CHAR_BITS-1:0] CH_BSL   = CHAR_BITS'(8'h5C);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Quote state of the current argument.
    typedef enum logic [1:0] {
        Q_NONE    = 2'd0,
        Q_DELIM   = 2'd1,
        Q_STARTED = 2'd2
    } quote_state_t;

    // One result transfer.
    typedef struct packed {
        logic [CHAR_BITS-1:0]  out_char;
        logic                  char_valid;
        logic                  arg_end;
        logic                  line_done;
        logic [COUNT_BITS-1:0] arg_count;
    } result_t;

    // All results caused by one input character: one or two.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

endpackage

[rtl/clas_front.sv]
// Front end of the argument splitter: accepts characters, applies the quote and
// backslash rules, and pushes the resulting transfers into the queue as one entry.
// Depends on clas_pkg.
module clas_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [clas_pkg::CHAR_BITS-1:0] s_ch,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output clas_pkg::entry_t              q_entry
);

    logic                           hist_reg;
    clas_pkg::quote_state_t         qs_reg, qs_next, qs_work;
    logic                           inarg_reg, inarg_next;
    logic                           bp_reg, bp_next;
    logic                           bbp_reg, bbp_next;
    logic                           pwb_reg, pwb_next;
    logic [clas_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_sat;

    logic                           accept;
    logic                           blank;
    logic                           consumed;
    logic                           bsl_emit;
    logic [clas_pkg::CHAR_BITS-1:0] bsl_char;
    logic                           main_emit;
    clas_pkg::result_t              bsl_res, main_res;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign blank     = (s_ch == clas_pkg::CH_SPACE) || (s_ch == clas_pkg::CH_TAB);
    assign cnt_sat   = (cnt_reg == clas_pkg::COUNT_MAX) ? cnt_reg
                                                         : cnt_reg + 16'd1;

    // Step logic: a held backslash is resolved first, then the character itself.
    always_comb begin
        qs_next    = qs_reg;
        qs_work    = qs_reg;
        inarg_next = inarg_reg;
        bp_next    = bp_reg;
        bbp_next   = bbp_reg;
        pwb_next   = pwb_reg;
        cnt_next   = cnt_reg;
        consumed   = 1'b0;
        bsl_emit   = 1'b0;
        bsl_char   = clas_pkg::CH_BSL;
        main_emit  = 1'b0;
        main_res   = '0;
        main_res.arg_count = cnt_reg;

        // Resolve the backslash held from the previous character.
        if (bp_reg) begin
            bp_next  = 1'b0;
            bbp_next = 1'b0;
            if (!hist_reg) begin
                if (s_ch == clas_pkg::CH_QUOTE) begin
                    if (!bbp_reg) begin
                        bsl_emit = 1'b1;
                        bsl_char = clas_pkg::CH_QUOTE;
                        consumed = 1'b1;
                    end
                end else begin
                    bsl_emit = 1'b1;
                end
            end else begin
                bsl_emit = 1'b1;
                if ((s_ch == clas_pkg::CH_QUOTE) ||
                    ((s_ch == clas_pkg::CH_BSL) && (qs_reg == clas_pkg::Q_DELIM))) begin
                    bsl_char = s_ch;
                    consumed = 1'b1;
                end
            end
        end

        // Handle the character itself.
        if (!consumed) begin
            if (s_ch == clas_pkg::CH_NUL) begin
                main_emit          = 1'b1;
                main_res.line_done = 1'b1;
                if (inarg_reg) begin
                    main_res.arg_end   = 1'b1;
                    main_res.arg_count = cnt_sat;
                end
                qs_next    = clas_pkg::Q_NONE;
                inarg_next = 1'b0;
                bp_next    = 1'b0;
                bbp_next   = 1'b0;
                pwb_next   = 1'b0;
                cnt_next   = '0;
            end else begin
                pwb_next = (s_ch == clas_pkg::CH_BSL);
                if (!inarg_reg && blank) begin
                    // Blanks between arguments cause no result.
                end else if (!inarg_reg && (s_ch == clas_pkg::CH_QUOTE)) begin
                    inarg_next = 1'b1;
                    qs_next    = clas_pkg::Q_DELIM;
                end else begin
                    if (!inarg_reg) begin
                        inarg_next = 1'b1;
                        qs_work    = clas_pkg::Q_NONE;
                        qs_next    = clas_pkg::Q_NONE;
                    end
                    if ((s_ch == clas_pkg::CH_QUOTE) && !hist_reg) begin
                        qs_next = (qs_work == clas_pkg::Q_NONE) ? clas_pkg::Q_STARTED
                                                                : clas_pkg::Q_NONE;
                    end else if (((s_ch == clas_pkg::CH_QUOTE) &&
                                  (qs_work == clas_pkg::Q_DELIM)) ||
                                 (blank && (qs_work == clas_pkg::Q_NONE))) begin
                        cnt_next           = cnt_sat;
                        inarg_next         = 1'b0;
                        main_emit          = 1'b1;
                        main_res.arg_end   = 1'b1;
                        main_res.arg_count = cnt_sat;
                    end else if (s_ch == clas_pkg::CH_BSL) begin
                        bp_next  = 1'b1;
                        bbp_next = pwb_reg;
                    end else begin
                        main_emit           = 1'b1;
                        main_res.out_char   = s_ch;
                        main_res.char_valid = 1'b1;
                    end
                end
            end
        end else begin
            pwb_next = (s_ch == clas_pkg::CH_BSL);
        end
    end

    // Build the queue entry from the resolved backslash and the character's result.
    always_comb begin
        bsl_res            = '0;
        bsl_res.out_char   = bsl_char;
        bsl_res.char_valid = 1'b1;
        bsl_res.arg_count  = cnt_reg;
        q_entry.first      = bsl_emit ? bsl_res : main_res;
        q_entry.second     = main_res;
        q_entry.two        = bsl_emit && main_emit;
    end

    assign q_push = accept && (bsl_emit || main_emit);

    // Splitter state and the mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= 1'b0;
            qs_reg    <= clas_pkg::Q_NONE;
            inarg_reg <= 1'b0;
            bp_reg    <= 1'b0;
            bbp_reg   <= 1'b0;
            pwb_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hist_reg <= cfg_data;
            end
            if (accept) begin
                qs_reg    <= qs_next;
                inarg_reg <= inarg_next;
                bp_reg    <= bp_next;
                bbp_reg   <= bbp_next;
                pwb_reg   <= pwb_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

[rtl/clas_queue.sv]
// Small register queue of result entries between the front and the back.
// Lets the front keep accepting characters while the back waits on its consumer.
// Depends on clas_pkg.
module clas_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  clas_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output clas_pkg::entry_t head_entry
);

    clas_pkg::entry_t               entries_reg [clas_pkg::QUEUE_DEPTH];
    logic [clas_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [clas_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [clas_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == clas_pkg::QCNT_BITS'(clas_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/clas_back.sv]
// Back end of the argument splitter: plays out the one or two transfers of the
// queue head entry on the result channel and marks the last one.
// Depends on clas_pkg.
module clas_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  clas_pkg::entry_t                head_entry,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [clas_pkg::CHAR_BITS-1:0]  m_out_char,
    output logic                            m_char_valid,
    output logic                            m_arg_end,
    output logic                            m_line_done,
    output logic [clas_pkg::COUNT_BITS-1:0] m_arg_count,
    output logic                            m_last
);

    logic              sub_reg, sub_next;
    clas_pkg::result_t cur;
    logic              xfer;

    // Select the transfer that is due from the head entry.
    assign cur          = sub_reg ? head_entry.second : head_entry.first;
    assign m_valid      = head_valid;
    assign m_out_char   = cur.out_char;
    assign m_char_valid = cur.char_valid;
    assign m_arg_end    = cur.arg_end;
    assign m_line_done  = cur.line_done;
    assign m_arg_count  = cur.arg_count;
    assign m_last       = sub_reg || !head_entry.two;

    assign xfer = m_valid && m_ready;
    assign pop  = xfer && m_last;

    // Step to the second transfer, and back once the entry leaves.
    always_comb begin
        sub_next = sub_reg;
        if (xfer) begin
            sub_next = !m_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

[rtl/command_line_argument_splitter.sv]
// Command-line argument splitter: takes one character per transfer and returns
// argument characters, end-of-argument markers and an end-of-line marker with
// the argument count. The block accepts one character per cycle while its queue
// is not full; a character causes zero, one or two result transfers, so the
// sustained rate is set by the result channel, which delivers one transfer per
// cycle while m_ready is high, and a four-entry queue between the classifying
// front end and the output back end absorbs bursts. Every result is registered in the queue.
// Depends on clas_pkg, clas_front, clas_queue and clas_back.
module command_line_argument_splitter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [clas_pkg::CHAR_BITS-1:0]  s_ch,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [clas_pkg::CHAR_BITS-1:0]  m_out_char,
    output logic                            m_char_valid,
    output logic                            m_arg_end,
    output logic                            m_line_done,
    output logic [clas_pkg::COUNT_BITS-1:0] m_arg_count,
    output logic                            m_last
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_head_valid;
    clas_pkg::entry_t q_push_entry;
    clas_pkg::entry_t q_head_entry;

    // Front end: character classification and splitter state.
    clas_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    // Queue of pending result entries.
    clas_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    // Back end: result channel.
    clas_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_entry   (q_head_entry),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_arg_end    (m_arg_end),
        .m_line_done  (m_line_done),
        .m_arg_count  (m_arg_count),
        .m_last       (m_last)
    );

endmodule

[rtl/clas_checker.sv]
// Port checker for the command-line argument splitter, bound to the top level.
// Watches the result channel only. Depends on clas_pkg.
module clas_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [clas_pkg::CHAR_BITS-1:0]  m_out_char,
    input logic                            m_char_valid,
    input logic                            m_arg_end,
    input logic                            m_line_done,
    input logic [clas_pkg::COUNT_BITS-1:0] m_arg_count,
    input logic                            m_last
);

    // A stalled result transfer stays offered with the same count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_arg_count))
        else $error("result transfer withdrawn while stalled");

    // The end of a line is always the last transfer caused by its character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_done |-> m_last)
        else $error("line end not marked as last transfer");

    // A character transfer never closes an argument or the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> !m_arg_end && !m_line_done)
        else $error("character transfer carries a closing flag");

    // A marker transfer carries no character bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> (m_out_char == '0) && (m_arg_end || m_line_done))
        else $error("marker transfer malformed");

endmodule

bind command_line_argument_splitter clas_checker u_clas_checker (.*);
